@@ src/vbc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared widths, item kinds, register indexes and the queue entry type of the
// voxel band classifier.
// ----------------------------------------------------------------------------
package vbc_pkg;

    localparam int POS_W      = 10;              // grid index and angle fields
    localparam int ANGLE_W    = 10;              // radius table address
    localparam int OFS_W      = 12;
    localparam int EXT_W      = 11;
    localparam int SHIFT_W    = OFS_W + 1;       // signed shifted coordinate
    localparam int COORD_W    = EXT_W;           // in-bounds coordinate < extent
    localparam int DIST_W     = 20;
    localparam int INT_W      = 16;
    localparam int ADDR_W     = 30;
    localparam int MEAN_W     = 24;
    localparam int CNT_W      = 31;
    localparam int SUM_W      = 46;
    localparam int FRAC_W     = 8;
    localparam int NUM_W      = SUM_W + FRAC_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_VOXEL  = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    localparam logic RES_BOUNDARY = 1'b0;
    localparam logic RES_MEAN     = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_I   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_J   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_K   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_I   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_J   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_K   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HALFWIDTH  = 3'd6;

    // one queued command; for loads distance carries the radius
    typedef struct packed {
        t_kind                kind;
        logic [COORD_W-1:0]   ci;
        logic [COORD_W-1:0]   cj;
        logic [COORD_W-1:0]   ck;
        logic [ANGLE_W-1:0]   angle;
        logic [DIST_W-1:0]    distance;
        logic [INT_W-1:0]     intensity;
    } t_cmd;

endpackage
`default_nettype wire

@@ src/voxel_band_classifier_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_band_classifier_core
// Classifies voxels against a polar contour held in a radius table, emits
// boundary band points and the interior mean on request.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------
//   input    | in        | i_in_valid / o_in_ready   | kind, pos, angle, dist ...
//   result   | out       | o_out_valid / i_out_ready | kind, coords, addr, mean
//   config   | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// the front takes one word per cycle into a 4-entry queue while it is not full;
// dropped voxels and unknown kinds never reach the back. the back takes a load
// in idle, an out-of-band voxel through lookup, a band voxel through lookup,
// multiply and output, a finish through the 55-step restoring divider and
// output, or straight to output if the interior is empty, so the back sets
// the sustained rate. reset is synchronous; the radius table is not cleared.
// results wait in the output register as the back runs on to its next result.
// ----------------------------------------------------------------------------
module voxel_band_classifier_core import vbc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [1:0]             i_kind,
    input  wire logic [POS_W-1:0]       i_pos_i,
    input  wire logic [POS_W-1:0]       i_pos_j,
    input  wire logic [POS_W-1:0]       i_pos_k,
    input  wire logic [POS_W-1:0]       i_angle_index,
    input  wire logic [DIST_W-1:0]      i_distance,
    input  wire logic [INT_W-1:0]       i_intensity,
    input  wire logic [DIST_W-1:0]      i_radius_value,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_result_kind,
    output logic [POS_W-1:0]            o_coord_i,
    output logic [POS_W-1:0]            o_coord_j,
    output logic [POS_W-1:0]            o_coord_k,
    output logic [POS_W-1:0]            o_angle_out,
    output logic [ADDR_W-1:0]           o_flat_address,
    output logic [MEAN_W-1:0]           o_mean_value,
    output logic [CNT_W-1:0]            o_voxel_count,
    output logic                        o_mean_valid
);

    logic [OFS_W-1:0]   r_offset_i;
    logic [OFS_W-1:0]   r_offset_j;
    logic [OFS_W-1:0]   r_offset_k;
    logic [EXT_W-1:0]   r_extent_i;
    logic [EXT_W-1:0]   r_extent_j;
    logic [EXT_W-1:0]   r_extent_k;
    logic [DIST_W-1:0]  r_halfwidth;

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    t_cmd               w_cmd;
    t_cmd               w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_i  <= '0;
            r_offset_j  <= '0;
            r_offset_k  <= '0;
            r_extent_i  <= EXT_W'(1024);
            r_extent_j  <= EXT_W'(1024);
            r_extent_k  <= EXT_W'(1024);
            r_halfwidth <= DIST_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OFFSET_I:  r_offset_i  <= i_cfg_data[OFS_W-1:0];
                CFG_OFFSET_J:  r_offset_j  <= i_cfg_data[OFS_W-1:0];
                CFG_OFFSET_K:  r_offset_k  <= i_cfg_data[OFS_W-1:0];
                CFG_EXTENT_I:  r_extent_i  <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_J:  r_extent_j  <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_K:  r_extent_k  <= i_cfg_data[EXT_W-1:0];
                CFG_HALFWIDTH: r_halfwidth <= i_cfg_data[DIST_W-1:0];
                default:       r_halfwidth <= r_halfwidth;
            endcase
        end
    end

    vbc_front u_front (
        .i_in_valid     (i_in_valid),
        .i_kind         (i_kind),
        .i_pos_i        (i_pos_i),
        .i_pos_j        (i_pos_j),
        .i_pos_k        (i_pos_k),
        .i_angle_index  (i_angle_index),
        .i_distance     (i_distance),
        .i_intensity    (i_intensity),
        .i_radius_value (i_radius_value),
        .i_offset_i     (r_offset_i),
        .i_offset_j     (r_offset_j),
        .i_offset_k     (r_offset_k),
        .i_extent_i     (r_extent_i),
        .i_extent_j     (r_extent_j),
        .i_extent_k     (r_extent_k),
        .i_fifo_full    (w_full),
        .o_in_ready     (o_in_ready),
        .o_push         (w_push),
        .o_cmd          (w_cmd)
    );

    vbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    vbc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_extent_j     (r_extent_j),
        .i_extent_k     (r_extent_k),
        .i_halfwidth    (r_halfwidth),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_result_kind  (o_result_kind),
        .o_coord_i      (o_coord_i),
        .o_coord_j      (o_coord_j),
        .o_coord_k      (o_coord_k),
        .o_angle_out    (o_angle_out),
        .o_flat_address (o_flat_address),
        .o_mean_value   (o_mean_value),
        .o_voxel_count  (o_voxel_count),
        .o_mean_valid   (o_mean_valid)
    );

endmodule
`default_nettype wire

@@ src/vbc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_front
// Decodes input words, shifts voxel coordinates by the offsets, drops voxels
// outside the image and pushes the surviving commands into the queue.
// ----------------------------------------------------------------------------
module vbc_front import vbc_pkg::*; (
    input  wire logic                  i_in_valid,
    input  wire logic [1:0]            i_kind,
    input  wire logic [POS_W-1:0]      i_pos_i,
    input  wire logic [POS_W-1:0]      i_pos_j,
    input  wire logic [POS_W-1:0]      i_pos_k,
    input  wire logic [POS_W-1:0]      i_angle_index,
    input  wire logic [DIST_W-1:0]     i_distance,
    input  wire logic [INT_W-1:0]      i_intensity,
    input  wire logic [DIST_W-1:0]     i_radius_value,
    input  wire logic [OFS_W-1:0]      i_offset_i,
    input  wire logic [OFS_W-1:0]      i_offset_j,
    input  wire logic [OFS_W-1:0]      i_offset_k,
    input  wire logic [EXT_W-1:0]      i_extent_i,
    input  wire logic [EXT_W-1:0]      i_extent_j,
    input  wire logic [EXT_W-1:0]      i_extent_k,
    input  wire logic                  i_fifo_full,
    output logic                       o_in_ready,
    output logic                       o_push,
    output t_cmd                       o_cmd
);

    logic [SHIFT_W-1:0] w_ci;
    logic [SHIFT_W-1:0] w_cj;
    logic [SHIFT_W-1:0] w_ck;
    logic               w_inb;
    logic               w_keep;

    function automatic logic [SHIFT_W-1:0] shift_coord(
        input logic [POS_W-1:0] pos,
        input logic [OFS_W-1:0] ofs
    );
        shift_coord = {{(SHIFT_W-POS_W){1'b0}}, pos} + {ofs[OFS_W-1], ofs};
    endfunction

    // strictly above zero and below the extent
    function automatic logic in_bounds(
        input logic [SHIFT_W-1:0] c,
        input logic [EXT_W-1:0]   ext
    );
        in_bounds = !c[SHIFT_W-1] && (c != '0) &&
                    (c[SHIFT_W-2:0] < {{(SHIFT_W-1-EXT_W){1'b0}}, ext});
    endfunction

    always_comb begin
        w_ci  = shift_coord(i_pos_i, i_offset_i);
        w_cj  = shift_coord(i_pos_j, i_offset_j);
        w_ck  = shift_coord(i_pos_k, i_offset_k);
        w_inb = in_bounds(w_ci, i_extent_i) && in_bounds(w_cj, i_extent_j) &&
                in_bounds(w_ck, i_extent_k);

        case (t_kind'(i_kind))
            KIND_LOAD:   w_keep = 1'b1;
            KIND_VOXEL:  w_keep = w_inb;
            KIND_FINISH: w_keep = 1'b1;
            default:     w_keep = 1'b0;
        endcase

        o_cmd.kind      = t_kind'(i_kind);
        o_cmd.ci        = w_ci[COORD_W-1:0];
        o_cmd.cj        = w_cj[COORD_W-1:0];
        o_cmd.ck        = w_ck[COORD_W-1:0];
        o_cmd.angle     = i_angle_index[ANGLE_W-1:0];
        o_cmd.distance  = (t_kind'(i_kind) == KIND_LOAD) ? i_radius_value : i_distance;
        o_cmd.intensity = i_intensity;
    end

    assign o_in_ready = !i_fifo_full;
    assign o_push     = i_in_valid && !i_fifo_full && w_keep;

endmodule
`default_nettype wire

@@ src/vbc_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module vbc_fifo import vbc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    t_cmd                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/vbc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_back
// Executes queued commands: radius table writes, interior accumulation, band
// test with flat address, and the mean by restoring division.
// ----------------------------------------------------------------------------
module vbc_back import vbc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_empty,
    input  wire t_cmd                  i_head,
    output logic                       o_pop,
    input  wire logic [EXT_W-1:0]      i_extent_j,
    input  wire logic [EXT_W-1:0]      i_extent_k,
    input  wire logic [DIST_W-1:0]     i_halfwidth,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_result_kind,
    output logic [POS_W-1:0]           o_coord_i,
    output logic [POS_W-1:0]           o_coord_j,
    output logic [POS_W-1:0]           o_coord_k,
    output logic [POS_W-1:0]           o_angle_out,
    output logic [ADDR_W-1:0]          o_flat_address,
    output logic [MEAN_W-1:0]          o_mean_value,
    output logic [CNT_W-1:0]           o_voxel_count,
    output logic                       o_mean_valid
);

    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int ROW_W     = 2 * COORD_W + 1;
    localparam int PROD_W    = ROW_W + EXT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    logic [DIST_W-1:0]      r_table [1 << ANGLE_W];
    logic [DIST_W-1:0]      r_radius;

    t_state                 r_state;
    t_cmd                   r_cmd;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_total;
    logic [2*COORD_W-1:0]   r_mul;
    logic [ADDR_W-1:0]      r_prod;
    logic [CNT_W-1:0]       r_den;
    logic [CNT_W-1:0]       r_rem;
    logic [NUM_W-1:0]       r_quo;
    logic [DIV_CNT_W-1:0]   r_div_cnt;

    logic                   w_interior;
    logic                   w_in_band;
    logic [DIST_W:0]        w_r_plus;
    logic [DIST_W:0]        w_d_plus;
    logic [SUM_W:0]         w_sum_nx;
    logic                   w_acc_ok;
    logic [ROW_W-1:0]       w_row;
    logic [PROD_W-1:0]      w_prod;
    logic [NUM_W-1:0]       w_num;
    logic [CNT_W:0]         w_rem_sh;
    logic                   w_ge;
    logic [CNT_W:0]         w_diff;
    logic                   w_out_free;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // radius table, registered read
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == KIND_LOAD)) begin
            r_table[i_head.angle] <= i_head.distance;
        end
        if (o_pop && (i_head.kind == KIND_VOXEL)) begin
            r_radius <= r_table[i_head.angle];
        end
    end

    always_comb begin
        w_interior = r_cmd.distance < r_radius;
        w_r_plus   = {1'b0, r_radius} + {1'b0, i_halfwidth};
        w_d_plus   = {1'b0, r_cmd.distance} + {1'b0, i_halfwidth};
        w_in_band  = ({1'b0, r_cmd.distance} <= w_r_plus) &&
                     (w_d_plus >= {1'b0, r_radius});
        w_sum_nx   = {1'b0, r_sum} + (SUM_W+1)'(r_cmd.intensity);
        // saturation: both hold once either accumulator is full
        w_acc_ok   = w_interior && (r_total != '1) && !w_sum_nx[SUM_W];
        w_row      = {1'b0, r_mul} + ROW_W'(r_cmd.cj);
        w_prod     = w_row * PROD_W'(i_extent_k);
        // sum * 256 + count / 2
        w_num      = {1'b0, r_sum, {FRAC_W{1'b0}}} + NUM_W'(r_total[CNT_W-1:1]);
        w_rem_sh   = {r_rem, r_quo[NUM_W-1]};
        w_ge       = w_rem_sh >= {1'b0, r_den};
        w_diff     = w_rem_sh - {1'b0, r_den};
        w_out_free = !o_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_sum       <= '0;
            r_total     <= '0;
            r_div_cnt   <= '0;
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_OUT)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_head;
                        case (i_head.kind)
                            KIND_VOXEL: r_state <= S_LOOK;
                            KIND_FINISH: begin
                                r_den     <= r_total;
                                r_quo     <= w_num;
                                r_rem     <= '0;
                                r_div_cnt <= DIV_CNT_W'(NUM_W);
                                r_sum     <= '0;
                                r_total   <= '0;
                                r_state   <= (r_total == '0) ? S_OUT : S_DIV;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LOOK: begin
                    if (w_acc_ok) begin
                        r_sum   <= w_sum_nx[SUM_W-1:0];
                        r_total <= r_total + 1'b1;
                    end
                    r_mul   <= r_cmd.ci * i_extent_j;
                    r_state <= w_in_band ? S_MUL : S_IDLE;
                end
                S_MUL: begin
                    r_prod  <= w_prod[ADDR_W-1:0];
                    r_state <= S_OUT;
                end
                S_DIV: begin
                    r_rem     <= w_ge ? w_diff[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
                    r_quo     <= {r_quo[NUM_W-2:0], w_ge};
                    r_div_cnt <= r_div_cnt - 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_cmd.kind == KIND_FINISH) begin
                            o_result_kind  <= RES_MEAN;
                            o_coord_i      <= '0;
                            o_coord_j      <= '0;
                            o_coord_k      <= '0;
                            o_angle_out    <= '0;
                            o_flat_address <= '0;
                            o_voxel_count  <= r_den;
                            o_mean_valid   <= (r_den != '0);
                            o_mean_value   <= (r_den != '0) ? r_quo[MEAN_W-1:0] : '0;
                        end else begin
                            o_result_kind  <= RES_BOUNDARY;
                            o_coord_i      <= r_cmd.ci[POS_W-1:0];
                            o_coord_j      <= r_cmd.cj[POS_W-1:0];
                            o_coord_k      <= r_cmd.ck[POS_W-1:0];
                            o_angle_out    <= r_cmd.angle;
                            o_flat_address <= r_prod + ADDR_W'(r_cmd.ck);
                            o_voxel_count  <= '0;
                            o_mean_valid   <= 1'b0;
                            o_mean_value   <= '0;
                        end
                    end else if (o_out_valid && i_out_ready) begin
                        o_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
